[hw/rtl/msk_pkg.sv]
`timescale 1ns / 1ps

package msk_pkg;

  // Default sizing of the stack.
  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the request and result fields on the ports.
  localparam int VAL_PORT_W   = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_PORT_W = 7;

  // Request type codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;   // a request is accepted this cycle
    logic scan;   // a minimum rescan is in progress
    logic emit;   // a result is produced this cycle
  } msk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_scan;  // the offered request pops the recorded minimum off a stack of more than one entry
    logic scan_done;   // the last entry of the rescan is compared now
    logic skid_full;   // the result skid register is occupied
  } msk_stat_t;

  // One result as it sits in the output registers.
  typedef struct packed {
    status_t                  status;
    logic [VAL_PORT_W-1:0]    min_value;
    logic                     stack_empty;
    logic [COUNT_PORT_W-1:0]  entry_count;
  } msk_res_t;

endpackage

[hw/rtl/msk_ctrl.sv]
`timescale 1ns / 1ps

module msk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  msk_pkg::msk_stat_t stat,
  output msk_pkg::msk_cmd_t  cmd
);
  import msk_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // New requests wait while a rescan runs or the skid holds a result.
  assign in_stall = (state_r != S_IDLE) || stat.skid_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd.exec  = accept;
    cmd.scan  = (state_r == S_SCAN);
    cmd.emit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.needs_scan) begin
            state_nxt = S_SCAN;
          end else begin
            cmd.emit = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/msk_dp.sv]
`timescale 1ns / 1ps

module msk_dp #(
  parameter int DEPTH       = msk_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = msk_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  msk_pkg::msk_cmd_t                     cmd,
  output msk_pkg::msk_stat_t                    stat,
  input  logic                                  in_req_type,
  input  logic signed [msk_pkg::VAL_PORT_W-1:0] in_push_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output msk_pkg::msk_res_t                     out_res
);
  import msk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [CW-1:0]                 count_r, count_nxt;
  logic signed [VALUE_WIDTH-1:0] min_r, min_nxt;
  logic [AW-1:0]                 pos_r, pos_nxt;

  logic [AW-1:0]                 scan_addr_r;
  logic [AW-1:0]                 rd_idx_r;
  logic                          rd_vld_r;
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic                          issue;

  logic signed [VALUE_WIDTH-1:0] push_val;
  logic                          do_push;
  status_t                       exec_status;
  status_t                       res_status;
  msk_res_t                      res_new;

  logic     ov_r, ov_nxt, sv_r, sv_nxt;
  msk_res_t o_r, o_nxt, s_r, s_nxt;

  // Sign-extend or wrap the 32-bit request value to the stored width.
  assign push_val = VALUE_WIDTH'(in_push_value);
  assign do_push  = cmd.exec && (in_req_type == REQ_PUSH) && (count_r != CW'(DEPTH));

  assign stat.needs_scan = (in_req_type == REQ_POP) && (count_r > CW'(1))
                           && (CW'(pos_r) == count_r - CW'(1));
  assign stat.scan_done  = rd_vld_r && (CW'(rd_idx_r) == count_r - CW'(1));
  assign stat.skid_full  = sv_r;

  assign issue = cmd.scan && (CW'(scan_addr_r) < count_r);

  always_comb begin
    count_nxt   = count_r;
    min_nxt     = min_r;
    pos_nxt     = pos_r;
    exec_status = ST_DONE;
    if (cmd.exec) begin
      if (in_req_type == REQ_PUSH) begin
        if (count_r == CW'(DEPTH)) begin
          exec_status = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          if ((count_r == '0) || (push_val < min_r)) begin
            min_nxt = push_val;
            pos_nxt = count_r[AW-1:0];
          end
        end
      end else begin
        if (count_r == '0) begin
          exec_status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            min_nxt = '0;
            pos_nxt = '0;
          end
        end
      end
    end
    // Rescan: the first entry seeds the running minimum, later ones replace
    // it only when strictly smaller so the lowest position wins on ties.
    if (rd_vld_r && ((rd_idx_r == '0) || (rd_data_r < min_r))) begin
      min_nxt = rd_data_r;
      pos_nxt = rd_idx_r;
    end
  end

  assign res_status          = cmd.scan ? ST_DONE : exec_status;
  assign res_new.status      = res_status;
  assign res_new.min_value   = (count_nxt == '0) ? '0 : VAL_PORT_W'($unsigned(min_nxt));
  assign res_new.stack_empty = (count_nxt == '0);
  assign res_new.entry_count = COUNT_PORT_W'(count_nxt);

  // Two-entry result queue: output register plus skid register.
  always_comb begin
    ov_nxt = ov_r;
    sv_nxt = sv_r;
    o_nxt  = o_r;
    s_nxt  = s_r;
    if (ov_r && !out_stall) begin
      if (sv_r) begin
        o_nxt  = s_r;
        sv_nxt = 1'b0;
      end else begin
        ov_nxt = 1'b0;
      end
    end
    if (cmd.emit) begin
      if (!ov_nxt) begin
        o_nxt  = res_new;
        ov_nxt = 1'b1;
      end else begin
        s_nxt  = res_new;
        sv_nxt = 1'b1;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_res   = o_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[count_r[AW-1:0]] <= push_val;
    end
    if (issue) begin
      rd_data_r <= mem[scan_addr_r];
    end
    rd_idx_r <= scan_addr_r;
    o_r      <= o_nxt;
    s_r      <= s_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      min_r       <= '0;
      pos_r       <= '0;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      ov_r        <= 1'b0;
      sv_r        <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      min_r    <= min_nxt;
      pos_r    <= pos_nxt;
      rd_vld_r <= issue;
      ov_r     <= ov_nxt;
      sv_r     <= sv_nxt;
      if (cmd.exec) begin
        scan_addr_r <= '0;
      end else if (issue) begin
        scan_addr_r <= scan_addr_r + AW'(1);
      end
    end
  end

endmodule

[hw/rtl/min_tracking_stack_core.sv]
`timescale 1ns / 1ps
// Push, plain pop and refused requests: the result is registered on acceptance, and
// a new request can be taken every cycle while the result queue has room.
// A pop that removes the recorded minimum rescans the N remaining entries through the
// single read port of the value memory; no request is taken until its result is produced.
// Reset (rst_n low, synchronous) empties the stack and the result queue; memory is not cleared.

module min_tracking_stack_core #(
  parameter int DEPTH       = msk_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = msk_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_req_type,
  input  logic signed [msk_pkg::VAL_PORT_W-1:0]   in_push_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [msk_pkg::STATUS_W-1:0]            out_status,
  output logic signed [msk_pkg::VAL_PORT_W-1:0]   out_min_value,
  output logic                                    out_stack_empty,
  output logic [msk_pkg::COUNT_PORT_W-1:0]        out_entry_count
);
  import msk_pkg::*;

  // The controller sequences each request: it accepts when idle and the
  // result skid is free, and parks in a scan state while the datapath
  // walks the memory to find a new minimum after the old one was popped.
  msk_cmd_t  cmd;
  msk_stat_t stat;
  msk_res_t  res;

  msk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the value memory, the entry count, the recorded
  // minimum with its position, the rescan address pipeline and the
  // two-deep result queue that decouples request and result sides.
  msk_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (res)
  );

  // Each result field leaves the block on its own port.
  assign out_status      = res.status;
  assign out_min_value   = res.min_value;
  assign out_stack_empty = res.stack_empty;
  assign out_entry_count = res.entry_count;

endmodule

[hw/rtl/msk_chk.sv]
`timescale 1ns / 1ps

module msk_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [msk_pkg::STATUS_W-1:0]          out_status,
  input logic [msk_pkg::VAL_PORT_W-1:0]        out_min_value,
  input logic                                  out_stack_empty,
  input logic [msk_pkg::COUNT_PORT_W-1:0]      out_entry_count
);
  import msk_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_min_value) && $stable(out_stack_empty) && $stable(out_entry_count))
    else $error("stalled result changed");

  // An empty stack reports no entries and a zero minimum.
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_empty |-> (out_entry_count == '0) && (out_min_value == '0))
    else $error("empty result with nonzero fields");

  // A refused pop only happens on an empty stack.
  a_pop_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_stack_empty)
    else $error("pop refused on nonempty stack");

  // A refused push only happens on a full, hence nonempty, stack.
  a_push_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> !out_stack_empty)
    else $error("push refused on empty stack");

endmodule

bind min_tracking_stack_core msk_chk u_msk_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_min_value   (out_min_value),
  .out_stack_empty (out_stack_empty),
  .out_entry_count (out_entry_count)
);

[bench/tb_min_tracking_stack_core.sv]
`timescale 1ns / 1ps

module tb_min_tracking_stack_core;
  import msk_pkg::*;

  localparam int STACK_DEPTH  = DEPTH_DEF;
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  // A pop of the minimum rescans every remaining entry, so it is the slowest
  // single request; the drain at the end is sized from that.
  localparam int DRAIN_CYCLES = STACK_DEPTH + 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 13;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_req_type = REQ_PUSH;
  logic signed [VAL_PORT_W-1:0] in_push_value = '0;

  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [STATUS_W-1:0]          out_status;
  logic signed [VAL_PORT_W-1:0] out_min_value;
  logic                         out_stack_empty;
  logic [COUNT_PORT_W-1:0]      out_entry_count;

  min_tracking_stack_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_min_value   (out_min_value),
    .out_stack_empty (out_stack_empty),
    .out_entry_count (out_entry_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the stack. It is only ever updated at the moment the block
  // accepts a request, so it always matches what the block has committed to.
  logic signed [VAL_PORT_W-1:0] shadow_vals [STACK_DEPTH];
  int                           shadow_count = 0;
  logic signed [VAL_PORT_W-1:0] shadow_min = '0;
  int                           shadow_min_pos = 0;

  // Results the block owes us, oldest first.
  msk_res_t awaited_replies[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;

  // Traffic shaping shared by the sender, the receiver and the tests.
  bit                           calm = 1'b0;
  bit                           hold_pending = 1'b0;
  int                           hold_left = 0;
  logic signed [VAL_PORT_W-1:0] recent_push = '0;

  // Applies one request to the shadow stack and returns the result the block
  // has to produce for it. A push takes the new value as minimum only when it
  // is strictly smaller, so among equal minima the lowest position wins. A pop
  // of the recorded minimum rescans from the bottom with the same rule.
  function automatic msk_res_t apply_stack_request(logic kind,
                                                   logic signed [VAL_PORT_W-1:0] val);
    msk_res_t res;
    int       i;
    res.status = ST_DONE;
    if (kind == REQ_PUSH) begin
      if (shadow_count >= STACK_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        shadow_vals[shadow_count] = val;
        if (shadow_count == 0 || val < shadow_min) begin
          shadow_min     = val;
          shadow_min_pos = shadow_count;
        end
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      shadow_count--;
      if (shadow_count == 0) begin
        shadow_min     = '0;
        shadow_min_pos = 0;
      end else if (shadow_min_pos == shadow_count) begin
        shadow_min     = shadow_vals[0];
        shadow_min_pos = 0;
        for (i = 1; i < shadow_count; i++) begin
          if (shadow_vals[i] < shadow_min) begin
            shadow_min     = shadow_vals[i];
            shadow_min_pos = i;
          end
        end
      end
    end
    res.min_value   = (shadow_count == 0) ? '0 : shadow_min;
    res.stack_empty = (shadow_count == 0);
    res.entry_count = shadow_count[COUNT_PORT_W-1:0];
    return res;
  endfunction

  // Offers one request and blocks until the block takes it. Inputs only move on
  // the falling edge; a random gap may drop valid first, unless traffic is calm.
  // Valid stays high between back-to-back requests, so it is never lowered and
  // raised in the same time step.
  task automatic send_request(input logic kind, input logic signed [VAL_PORT_W-1:0] val);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < IDLE_PCT) gap = 1;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_push_value <= val;
    do @(posedge clk); while (in_stall);
    awaited_replies.push_back(apply_stack_request(kind, val));
    if (kind == REQ_PUSH) recent_push = val;
  endtask

  // Push values drawn from several families: the full 32-bit range so every
  // bit toggles, a narrow band so equal minima are common, the extremes, and
  // falling runs that keep the minimum on top so pops trigger rescans.
  function automatic logic signed [VAL_PORT_W-1:0] pick_push_value();
    logic signed [VAL_PORT_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $signed($urandom_range(15)) - 8;
      2: begin
        case ($urandom_range(3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = recent_push - $signed($urandom_range(1, 5));
    endcase
    return v;
  endfunction

  task automatic random_walk(input int n_items, input int push_pct);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < push_pct) send_request(REQ_PUSH, pick_push_value());
      else send_request(REQ_POP, $urandom);
    end
  endtask

  // Hand-picked requests: pop of an empty stack, both ends of the value range,
  // an equal minimum pushed above the recorded one, pops of the minimum that
  // force a rescan, a pop of a non-minimum, and the pop of the last entry.
  task automatic test_directed_cases();
    calm = 1'b1;
    send_request(REQ_POP,  $urandom);
    send_request(REQ_PUSH, 32'sh7FFF_FFFF);
    send_request(REQ_PUSH, 32'sh0000_0000);
    send_request(REQ_PUSH, -1);
    send_request(REQ_PUSH, -1);
    send_request(REQ_PUSH, 32'sh8000_0000);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_PUSH, 32'sh5);
    send_request(REQ_PUSH, 32'sh5);
    send_request(REQ_PUSH, 32'sh5555_5555);
    send_request(REQ_PUSH, 32'shAAAA_AAAA);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    send_request(REQ_POP,  $urandom);
    calm = 1'b0;
  endtask

  // Fill to capacity, get refused while full, then drain and get refused while
  // empty again.
  task automatic test_fill_and_drain();
    while (shadow_count < STACK_DEPTH) send_request(REQ_PUSH, pick_push_value());
    repeat (3) send_request(REQ_PUSH, pick_push_value());
    while (shadow_count > 0) send_request(REQ_POP, $urandom);
    send_request(REQ_POP, $urandom);
  endtask

  // The receiver stops taking results for a long while; the sender keeps
  // offering requests until the block has to stall its input.
  task automatic test_result_backpressure();
    hold_pending = 1'b1;
    random_walk(120, 65);
  endtask

  // Mostly random traffic. The push share swings so the stack sweeps between
  // empty and full many times; the first stretch runs with no idling at all.
  task automatic test_random_traffic();
    calm = 1'b1;
    random_walk(300, 55);
    calm = 1'b0;
    for (int round = 0; round < 3; round++) begin
      random_walk(120, 75);
      random_walk(80, 50);
      random_walk(120, 25);
    end
  endtask

  // Receiver: random stalls on the falling edge, or a long counted hold-off
  // when a test asks for one. Exactly one assignment to out_stall per edge.
  always @(negedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Result checker: each result taken on a rising edge is compared with the
  // oldest outstanding expectation, field by field.
  always @(posedge clk) begin : check_result
    msk_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: status=%0d min_value=%0d stack_empty=%0d entry_count=%0d",
               out_status, out_min_value, out_stack_empty, out_entry_count);
        mismatch_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_min_value !== want.min_value) begin
          $error("min_value: expected %0d, actual %0d", $signed(want.min_value), out_min_value);
          mismatch_count++;
        end
        if (out_stack_empty !== want.stack_empty) begin
          $error("stack_empty: expected %0d, actual %0d", want.stack_empty, out_stack_empty);
          mismatch_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, out_entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_fill_and_drain();
    test_result_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every owed result, then a little longer to catch stray ones.
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
